// ===== design/spim0s_pkg.sv =====
// shared types and constants for the spi mode 0 slave shifter
package spim0s_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned LevelW        = 5;
  localparam int unsigned QueueDepthDef = 16;
  localparam logic [ByteW-1:0] FillRst  = 8'hFF;

  // kind of an input transaction
  typedef enum logic {
    CmdSample = 1'b0,
    CmdPush   = 1'b1
  } cmd_e;

  // queue operations requested by one accepted transaction
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } q_ctrl_t;

endpackage

// ===== design/spim0s_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
module spim0s_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spim0s_queue.sv =====
// response byte queue: ram storage, pointers, count and a prefetched head byte
module spim0s_queue #(
  parameter int unsigned QueueDepth = spim0s_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spim0s_pkg::q_ctrl_t                 ctrl_i,
  input  logic [spim0s_pkg::ByteW-1:0]        push_data_i,
  output logic                                full_o,
  output logic [$clog2(QueueDepth+1)-1:0]     count_o,
  output logic [spim0s_pkg::ByteW-1:0]        front_o
);
  import spim0s_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic [AddrW-1:0] head_q, head_d, head_nx;
  logic [AddrW-1:0] tail_q, tail_d, tail_nx;
  logic [CntW-1:0]  count_q, count_d;
  logic             pend_q;
  logic [ByteW-1:0] front_q, front_d;
  logic [ByteW-1:0] rdata;
  logic             push_ok;
  logic             empty;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty   = (count_q == '0);
  assign push_ok = ctrl_i.push && !full_o;

  assign head_nx = (head_q == AddrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == AddrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;

  spim0s_ram #(
    .Width (ByteW),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail_q),
    .wdata_i (push_data_i),
    .re_i    (ctrl_i.pop),
    .raddr_i (head_nx),
    .rdata_o (rdata)
  );

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (push_ok) begin
      tail_d  = tail_nx;
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = head_nx;
      count_d = count_q - 1'b1;
    end
  end

  // a push into an empty queue lands in the head byte directly,
  // otherwise the head byte follows the read issued by the last pop
  always_comb begin
    front_d = front_q;
    if (push_ok && empty) begin
      front_d = push_data_i;
    end else if (pend_q) begin
      front_d = rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      pend_q  <= ctrl_i.pop;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign count_o = count_q;
  assign front_o = front_q;

endmodule

// ===== design/spi_mode0_slave_shifter.sv =====
// top level of the spi mode 0 slave shifter
// Spi mode 0 slave that works on sampled pin levels. Every input transaction is
// either a pin sample (cmd 0: sclk, mosi, active-low select) or a push of one
// response byte (cmd 1). Each input transaction yields exactly one output
// transaction carrying the miso level, a received byte flag and value, a filler
// flag, a dropped-push flag and the queue fill level. The block takes one
// transaction per clock cycle; results pass through the output register,
// and the input stalls only while that register holds a result whose consumer is
// stalling. Response bytes live in a ram of QueueDepth entries; the byte at the
// queue head is prefetched via the ram read register after each pop, which is in
// time because two pops are always at least two transactions apart. A push to a
// full queue is discarded and flagged. Falling select clears bit alignment, loads
// the fill byte and flushes the queue before the clock edge of the same sample is
// handled. The fill byte register is written through its own valid/ready port,
// which is always ready, and should only be written while the block is idle.
module spi_mode0_slave_shifter #(
  parameter int unsigned QueueDepth = spim0s_pkg::QueueDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // fill byte register write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spim0s_pkg::ByteW-1:0]        cfg_fill_byte_i,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_cmd_i,
  input  logic                                in_sclk_level_i,
  input  logic                                in_mosi_level_i,
  input  logic                                in_select_n_i,
  input  logic [spim0s_pkg::ByteW-1:0]        in_push_data_i,
  // output transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_miso_level_o,
  output logic                                out_rx_valid_o,
  output logic [spim0s_pkg::ByteW-1:0]        out_rx_data_o,
  output logic                                out_filler_used_o,
  output logic                                out_push_dropped_o,
  output logic [spim0s_pkg::LevelW-1:0]       out_queue_level_o
);
  import spim0s_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // configuration
  logic [ByteW-1:0] fill_q;

  // pin history and shifters
  logic             prev_sclk_q, prev_sclk_d;
  logic             prev_sel_n_q, prev_sel_n_d;
  logic [ByteW-1:0] rx_shift_q, rx_shift_d;
  logic [2:0]       rx_cnt_q, rx_cnt_d;
  logic [ByteW-1:0] tx_shift_q, tx_shift_d;
  logic [2:0]       tx_cnt_q, tx_cnt_d;
  logic             miso_q, miso_d;

  // output register
  logic             out_valid_q;
  logic             o_miso_q, o_rx_valid_q, o_filler_q, o_dropped_q;
  logic [ByteW-1:0] o_rx_data_q;
  logic [LevelW-1:0] o_level_q;

  // per-transaction decode
  logic             acc, is_pin, sel_fall, sclk_rise, sclk_fall;
  logic [2:0]       rx_cnt0, tx_cnt0;
  logic [ByteW-1:0] tx_sh0, tx_src;
  logic             boundary, rx_valid, filler, dropped;
  logic [ByteW-1:0] rx_data;
  logic [CntW-1:0]  level;
  logic [CntW+LevelW-1:0] level_ext;

  // queue interface
  q_ctrl_t          q_ctrl;
  logic             q_full;
  logic [CntW-1:0]  q_count;
  logic [ByteW-1:0] q_front;

  assign cfg_ready_o = 1'b1;

  // the input may advance whenever the output register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign is_pin    = (in_cmd_i == CmdSample);
  assign sel_fall  = is_pin && !in_select_n_i && prev_sel_n_q;
  assign sclk_rise = is_pin && in_sclk_level_i && !prev_sclk_q;
  assign sclk_fall = is_pin && !in_sclk_level_i && prev_sclk_q;

  // select falling is handled before the clock edge of the same sample
  assign rx_cnt0 = sel_fall ? 3'd0 : rx_cnt_q;
  assign tx_cnt0 = sel_fall ? 3'd0 : tx_cnt_q;
  assign tx_sh0  = sel_fall ? fill_q : tx_shift_q;

  assign boundary = sclk_fall && (tx_cnt0 == 3'd0);

  // a flushed queue is empty, so a pop never follows a select fall
  always_comb begin
    q_ctrl.flush = acc && sel_fall;
    q_ctrl.push  = acc && !is_pin;
    q_ctrl.pop   = acc && boundary && !sel_fall && (q_count != '0);
  end

  always_comb begin
    prev_sclk_d  = is_pin ? in_sclk_level_i : prev_sclk_q;
    prev_sel_n_d = is_pin ? in_select_n_i : prev_sel_n_q;

    // receive side, msb first on rising sclk
    rx_shift_d = rx_shift_q;
    rx_cnt_d   = rx_cnt0;
    rx_valid   = 1'b0;
    rx_data    = '0;
    if (sclk_rise) begin
      rx_shift_d = {rx_shift_q[ByteW-2:0], in_mosi_level_i};
      rx_cnt_d   = rx_cnt0 + 3'd1;
      if (rx_cnt_d == 3'd0) begin
        rx_valid = 1'b1;
        rx_data  = rx_shift_d;
      end
    end

    // transmit side, next bit on falling sclk, new byte at each boundary
    filler     = 1'b0;
    tx_src     = tx_sh0;
    tx_shift_d = tx_sh0;
    tx_cnt_d   = tx_cnt0;
    miso_d     = miso_q;
    if (sclk_fall) begin
      if (boundary) begin
        if (q_ctrl.pop) begin
          tx_src = q_front;
        end else begin
          tx_src = fill_q;
          filler = 1'b1;
        end
      end
      miso_d     = tx_src[ByteW-1];
      tx_shift_d = {tx_src[ByteW-2:0], 1'b0};
      tx_cnt_d   = tx_cnt0 + 3'd1;
    end

    dropped = !is_pin && q_full;

    // queue fill level after this transaction
    if (sel_fall) begin
      level = '0;
    end else if (!is_pin && !q_full) begin
      level = q_count + 1'b1;
    end else if (q_ctrl.pop) begin
      level = q_count - 1'b1;
    end else begin
      level = q_count;
    end
    level_ext = {{LevelW{1'b0}}, level};
  end

  spim0s_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_data_i (in_push_data_i),
    .full_o      (q_full),
    .count_o     (q_count),
    .front_o     (q_front)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= FillRst;
      prev_sclk_q  <= 1'b0;
      prev_sel_n_q <= 1'b1;
      rx_shift_q   <= '0;
      rx_cnt_q     <= 3'd0;
      tx_shift_q   <= FillRst;
      tx_cnt_q     <= 3'd0;
      miso_q       <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        fill_q <= cfg_fill_byte_i;
      end
      if (acc) begin
        prev_sclk_q  <= prev_sclk_d;
        prev_sel_n_q <= prev_sel_n_d;
        rx_shift_q   <= rx_shift_d;
        rx_cnt_q     <= rx_cnt_d;
        tx_shift_q   <= tx_shift_d;
        tx_cnt_q     <= tx_cnt_d;
        miso_q       <= miso_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk_i) begin
    if (acc) begin
      o_miso_q     <= miso_d;
      o_rx_valid_q <= rx_valid;
      o_rx_data_q  <= rx_data;
      o_filler_q   <= filler;
      o_dropped_q  <= dropped;
      o_level_q    <= level_ext[LevelW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_miso_level_o   = o_miso_q;
  assign out_rx_valid_o     = o_rx_valid_q;
  assign out_rx_data_o      = o_rx_data_q;
  assign out_filler_used_o  = o_filler_q;
  assign out_push_dropped_o = o_dropped_q;
  assign out_queue_level_o  = o_level_q;

endmodule

// ===== tb/spi_mode0_slave_shifter_test.sv =====
// self-checking testbench for the spi mode 0 slave shifter
module spi_mode0_slave_shifter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spim0s_pkg::*;

  localparam int unsigned Depth      = QueueDepthDef;
  localparam int unsigned QuietLimit = 2000;  // idle cycles before the run is declared hung
  localparam int unsigned PhaseItems = 275;   // random transactions per fill byte setting
  localparam int unsigned NumPhases  = 5;

  typedef struct packed {
    cmd_e             cmd;
    logic             sclk;
    logic             mosi;
    logic             sel_n;
    logic [ByteW-1:0] pdata;
  } pin_item_t;

  typedef struct packed {
    logic              miso;
    logic              rx_valid;
    logic [ByteW-1:0]  rx_data;
    logic              filler;
    logic              dropped;
    logic [LevelW-1:0] level;
  } pin_result_t;

  logic              clk_i;
  logic              rst_ni             = 1'b0;
  logic              cfg_valid_i        = 1'b0;
  logic              cfg_ready_o;
  logic [ByteW-1:0]  cfg_fill_byte_i    = '0;
  logic              in_valid_i         = 1'b0;
  logic              in_stall_o;
  logic              in_cmd_i           = 1'b0;
  logic              in_sclk_level_i    = 1'b0;
  logic              in_mosi_level_i    = 1'b0;
  logic              in_select_n_i      = 1'b1;
  logic [ByteW-1:0]  in_push_data_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i        = 1'b0;
  logic              out_miso_level_o;
  logic              out_rx_valid_o;
  logic [ByteW-1:0]  out_rx_data_o;
  logic              out_filler_used_o;
  logic              out_push_dropped_o;
  logic [LevelW-1:0] out_queue_level_o;

  spi_mode0_slave_shifter #(
    .QueueDepth(Depth)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_fill_byte_i   (cfg_fill_byte_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_cmd_i          (in_cmd_i),
    .in_sclk_level_i   (in_sclk_level_i),
    .in_mosi_level_i   (in_mosi_level_i),
    .in_select_n_i     (in_select_n_i),
    .in_push_data_i    (in_push_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_miso_level_o  (out_miso_level_o),
    .out_rx_valid_o    (out_rx_valid_o),
    .out_rx_data_o     (out_rx_data_o),
    .out_filler_used_o (out_filler_used_o),
    .out_push_dropped_o(out_push_dropped_o),
    .out_queue_level_o (out_queue_level_o)
  );

  // transactions waiting to be driven, and results the shifter still owes us
  pin_item_t   samples_todo[$];
  pin_result_t results_due[$];

  int unsigned items_added = 0;
  int unsigned checked     = 0;
  int unsigned errors      = 0;

  // shadow copy of the shifter state
  logic             sclk_seen;
  logic             sel_seen;
  logic [ByteW-1:0] rx_shreg;
  logic [2:0]       rx_bits;
  logic [ByteW-1:0] tx_shreg;
  logic [2:0]       tx_bits;
  logic             miso_now;
  logic [ByteW-1:0] resp_mem [Depth];
  int unsigned      rd_ptr;
  int unsigned      wr_ptr;
  int unsigned      resp_cnt;
  logic [ByteW-1:0] fill_reg;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // advance the shadow shifter by one transaction and return what it should emit
  function automatic pin_result_t advance_shifter(input pin_item_t it);
    pin_result_t r;
    r = '0;
    if (it.cmd == CmdPush) begin
      // pins are ignored on a push, no edge can be seen
      if (resp_cnt >= Depth) begin
        r.dropped = 1'b1;
      end else begin
        resp_mem[wr_ptr] = it.pdata;
        wr_ptr = (wr_ptr == Depth - 1) ? 0 : wr_ptr + 1;
        resp_cnt++;
      end
    end else begin
      // select edge first: a falling select realigns and flushes before sclk is looked at
      if (it.sel_n != sel_seen) begin
        if (!it.sel_n) begin
          rx_bits  = '0;
          tx_bits  = '0;
          tx_shreg = fill_reg;
          rd_ptr   = 0;
          wr_ptr   = 0;
          resp_cnt = 0;
        end
        sel_seen = it.sel_n;
      end
      // sclk edges count regardless of select
      if (it.sclk != sclk_seen) begin
        if (it.sclk) begin
          rx_shreg = {rx_shreg[ByteW-2:0], it.mosi};
          rx_bits  = rx_bits + 3'd1;
          if (rx_bits == '0) begin
            r.rx_valid = 1'b1;
            r.rx_data  = rx_shreg;
          end
        end else begin
          if (tx_bits == '0) begin
            if (resp_cnt > 0) begin
              tx_shreg = resp_mem[rd_ptr];
              rd_ptr   = (rd_ptr == Depth - 1) ? 0 : rd_ptr + 1;
              resp_cnt--;
            end else begin
              tx_shreg = fill_reg;
              r.filler = 1'b1;
            end
          end
          miso_now = tx_shreg[ByteW-1];
          tx_shreg = tx_shreg << 1;
          tx_bits  = tx_bits + 3'd1;
        end
        sclk_seen = it.sclk;
      end
    end
    r.miso  = miso_now;
    r.level = LevelW'(resp_cnt);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("t=%0t result %0d: %s", $time, checked, what);
  endtask

  task automatic check_field(input string f, input logic [ByteW-1:0] g,
                             input logic [ByteW-1:0] w);
    if (g !== w) report_mismatch($sformatf("%s got %0h want %0h", f, g, w));
  endtask

  task automatic add_item(input cmd_e c, input logic s, input logic m, input logic sn,
                          input logic [ByteW-1:0] d);
    pin_item_t it;
    it.cmd   = c;
    it.sclk  = s;
    it.mosi  = m;
    it.sel_n = sn;
    it.pdata = d;
    samples_todo.push_back(it);
    items_added++;
  endtask

  // pin sample: push_data is a don't care, so randomize it
  task automatic add_pins(input logic s, input logic m, input logic sn);
    add_item(CmdSample, s, m, sn, ByteW'($urandom));
  endtask

  // push: pin fields are don't cares
  task automatic add_push(input logic [ByteW-1:0] d);
    add_item(CmdPush, 1'($urandom), 1'($urandom), 1'($urandom), d);
  endtask

  // a well-formed frame: select falls, a few response bytes queued, whole bytes clocked,
  // occasionally with a mid-frame deselect, repeated samples or late pushes
  task automatic queue_frame();
    int unsigned nbytes;
    add_pins(1'b0, 1'($urandom), 1'b1);
    add_pins(1'b0, 1'($urandom), 1'b0);
    repeat ($urandom_range(0, 4)) add_push(ByteW'($urandom));
    nbytes = $urandom_range(1, 3);
    repeat (nbytes * ByteW) begin
      if ($urandom_range(0, 9) == 0) add_push(ByteW'($urandom));
      if ($urandom_range(0, 59) == 0) add_pins(1'b0, 1'($urandom), 1'b1);
      add_pins(1'b0, 1'($urandom), 1'b0);
      if ($urandom_range(0, 7) == 0) add_pins(1'b0, 1'($urandom), 1'b0);
      add_pins(1'b1, 1'($urandom), 1'b0);
      if ($urandom_range(0, 7) == 0) add_pins(1'b1, 1'($urandom), 1'b0);
    end
    add_pins(1'b0, 1'($urandom), 1'b1);
  endtask

  task automatic write_fill(input logic [ByteW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_fill_byte_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fill_reg = v;
  endtask

  // input driver: one transaction at a time from samples_todo, with a random gap after each
  int unsigned gap_left = 0;
  bit          in_calm  = 1'b0;

  always @(posedge clk_i) begin : feed
    pin_item_t nxt;
    // hold the payload while the shifter stalls us
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (samples_todo.size() > 0) begin
        nxt = samples_todo.pop_front();
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_valid_i      <= 1'b1;
        in_cmd_i        <= nxt.cmd;
        in_sclk_level_i <= nxt.sclk;
        in_mosi_level_i <= nxt.mosi;
        in_select_n_i   <= nxt.sel_n;
        in_push_data_i  <= nxt.pdata;
        gap_left        <= in_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // every accepted transaction is predicted from what was actually on the ports
  always @(posedge clk_i) begin : predict
    pin_item_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.cmd   = cmd_e'(in_cmd_i);
      seen.sclk  = in_sclk_level_i;
      seen.mosi  = in_mosi_level_i;
      seen.sel_n = in_select_n_i;
      seen.pdata = in_push_data_i;
      results_due.push_back(advance_shifter(seen));
    end
  end

  // output side: compare each accepted result, then draw the stall before the next one
  int unsigned stall_left = 0;
  bit          out_calm   = 1'b0;

  always @(posedge clk_i) begin : observe
    pin_result_t want;
    int unsigned n;
    if (rst_ni) begin
      n = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = results_due.pop_front();
          check_field("miso_level", ByteW'(out_miso_level_o), ByteW'(want.miso));
          check_field("rx_valid", ByteW'(out_rx_valid_o), ByteW'(want.rx_valid));
          check_field("rx_data", out_rx_data_o, want.rx_data);
          check_field("filler_used", ByteW'(out_filler_used_o), ByteW'(want.filler));
          check_field("push_dropped", ByteW'(out_push_dropped_o), ByteW'(want.dropped));
          check_field("queue_level", ByteW'(out_queue_level_o), ByteW'(want.level));
          checked++;
        end
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        n = out_calm ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= n - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  // hang detection: any transaction on any channel resets the count
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("spi_mode0_slave_shifter: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned target;
    int unsigned pick;
    sclk_seen = 1'b0;
    sel_seen  = 1'b1;
    rx_shreg  = '0;
    rx_bits   = '0;
    tx_shreg  = FillRst;
    tx_bits   = '0;
    miso_now  = 1'b1;
    rd_ptr    = 0;
    wr_ptr    = 0;
    resp_cnt  = 0;
    fill_reg  = FillRst;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        // fill byte changes only with the shifter drained and quiet
        wait (checked == items_added);
        repeat (4) @(posedge clk_i);
        case (ph)
          1:       write_fill(8'h00);
          2:       write_fill(8'hFF);
          default: write_fill(ByteW'($urandom));
        endcase
      end

      if (ph == 0) begin
        // clock edges while deselected, rising then falling (filler goes out)
        add_pins(1'b0, 1'b0, 1'b1);
        add_pins(1'b1, 1'b1, 1'b1);
        add_pins(1'b0, 1'b0, 1'b1);
        // select falls on the same sample as a rising sclk
        add_pins(1'b1, 1'b1, 1'b0);
        // fill the queue to the brim, the last push is dropped
        add_push(8'h00);
        add_push(8'hFF);
        for (int k = 0; k < ByteW; k++) add_push(ByteW'(8'h80 >> k));
        repeat (Depth - ByteW - 1) add_push(ByteW'($urandom));
        // falling sclk pops the oldest byte
        add_pins(1'b0, 1'b0, 1'b0);
        add_pins(1'b1, 1'b0, 1'b0);
        // select rises: only remembered
        add_pins(1'b1, 1'b1, 1'b1);
        // select falls and sclk falls together: flush, then filler at the boundary
        add_pins(1'b0, 1'b1, 1'b0);
        add_push(8'h5A);
      end

      target = items_added + PhaseItems;
      while (items_added < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          queue_frame();
        end else if (pick == 7) begin
          // long push burst that can run the queue past full
          repeat ($urandom_range(12, 22)) add_push(ByteW'($urandom));
        end else begin
          // noise: anything the fields allow
          repeat ($urandom_range(1, 6)) begin
            add_item(cmd_e'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                     1'($urandom), ByteW'($urandom));
          end
        end
      end
    end

    wait (checked == items_added);
    repeat (8) @(posedge clk_i);
    if (results_due.size() != 0) report_mismatch("expected results never arrived");
    if (errors == 0) begin
      $display("spi_mode0_slave_shifter: match");
    end else begin
      $display("spi_mode0_slave_shifter: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/spim0s_pkg.sv
design/spim0s_ram.sv
design/spim0s_queue.sv
design/spi_mode0_slave_shifter.sv
tb/spi_mode0_slave_shifter_test.sv
